// ===== hdl/modular_inverse_ext_euclid_core_defines.svh =====
// Assertion macros shared by the modular inverse core.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH

// Same-cycle implication
`define MIE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MIE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mie_pkg.sv =====
`default_nettype none

package mie_pkg;

    // Width of the value, modulus, inverse and gcd ports
    localparam int unsigned OUT_W = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } mie_state_t;

    // Status of the shared divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== hdl/mie_divider.sv =====
`default_nettype none

`include "modular_inverse_ext_euclid_core_defines.svh"

// Restoring divider, one quotient bit per cycle. Alongside the remainder it
// accumulates quotient * mulval in Horner form, so no multiplier is needed.
module mie_divider
    import mie_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    input  wire logic [WIDTH-1:0] mulval,
    output div_status_t           status,
    output logic      [WIDTH-1:0] remainder,
    output logic      [WIDTH-1:0] product
);

    localparam int unsigned CNT_W = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [WIDTH-1:0] mul_reg, mul_next;
    logic [WIDTH-1:0] acc_reg, acc_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             ge;

    // One restoring step: shift in the next dividend bit, compare, subtract
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[WIDTH-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    // Step control and datapath
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        den_next   = den_reg;
        mul_next   = mul_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            dvd_next   = dividend;
            den_next   = divisor;
            mul_next   = mulval;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            dvd_next   = {dvd_reg[WIDTH-2:0], 1'b0};
            acc_next   = {acc_reg[WIDTH-2:0], 1'b0} + (ge ? mul_reg : '0);
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        mul_reg <= mul_next;
        acc_reg <= acc_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;
    assign product     = acc_reg;

    `MIE_ASSERT_IMP(a_no_restart, start, !busy_reg, "divider started while busy")
    `MIE_ASSERT_NXT(a_start_busy, start, busy_reg, "divider not busy after start")
    `MIE_ASSERT_IMP(a_done_idle, done_reg, !busy_reg, "divider done while still busy")

endmodule

`default_nettype wire

// ===== hdl/modular_inverse_ext_euclid_core.sv =====
// Modular inverse by the extended Euclidean algorithm.
// Input channel: value and modulus, transferred when in_valid and in_ready are
// both high. in_ready is high only while the sequencer is idle; one item is in
// work at a time.
// Output channel: inverse (0..modulus-1, zero when none exists), common_divisor
// and has_inverse, transferred when out_valid and out_ready are both high.
// The initial value % modulus and every Euclid round each run one pass of the
// shared bit-serial divider and then return to the check state. A zero modulus
// skips the divider and goes straight from idle to the finish state.
// in_ready returns as the result is loaded, in the same cycle that out_valid
// rises, so with the receiver keeping up the next item can transfer while the
// result is still offered.
// A finished result sits in the output register; if the receiver stalls, the
// next result waits in the finish state and no new item is taken until the
// output register frees up.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and
// drops out_valid; nothing else needs clearing.
`default_nettype none

`include "modular_inverse_ext_euclid_core_defines.svh"

module modular_inverse_ext_euclid_core
    import mie_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [OUT_W-1:0] value,
    input  wire logic [OUT_W-1:0] modulus,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [OUT_W-1:0] inverse,
    output logic      [OUT_W-1:0] common_divisor,
    output logic                  has_inverse
);

    mie_state_t       state_reg, state_next;

    logic [WIDTH-1:0] a_in, m_in;
    logic [WIDTH-1:0] r0_reg, r0_next;
    logic [WIDTH-1:0] r1_reg, r1_next;
    logic [WIDTH-1:0] u0_reg, u0_next;
    logic [WIDTH-1:0] u1_reg, u1_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic             odd_reg, odd_next;
    logic             zmod_reg, zmod_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] inverse_reg, inverse_next;
    logic [OUT_W-1:0] gcd_reg, gcd_next;
    logic             has_inv_reg, has_inv_next;

    logic             in_xfer, out_free, load_out;
    logic             div_start;
    logic [WIDTH-1:0] div_dividend, div_divisor, div_mulval;
    div_status_t      div_status;
    logic [WIDTH-1:0] div_rem, div_prod;

    logic             ok;
    logic [WIDTH-1:0] mag, inv_w;

    assign a_in     = WIDTH'(value);
    assign m_in     = WIDTH'(modulus);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Shared divide unit
    mie_divider #(
        .WIDTH(WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .mulval   (div_mulval),
        .status   (div_status),
        .remainder(div_rem),
        .product  (div_prod)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = (m_in == '0) ? ST_FINISH : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (div_status.done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (r1_reg == '0) ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                    state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: divider requests and output load
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = r0_reg;
        div_divisor  = r1_reg;
        div_mulval   = u1_reg;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // initial reduction value % modulus
                div_start    = in_xfer && (m_in != '0);
                div_dividend = a_in;
                div_divisor  = m_in;
                div_mulval   = '0;
            end
            ST_CHECK:
            begin
                div_start = (r1_reg != '0);
            end
            ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Remainder and coefficient pairs
    always_comb
    begin
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        u0_next   = u0_reg;
        u1_next   = u1_reg;
        mod_next  = mod_reg;
        odd_next  = odd_reg;
        zmod_next = zmod_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // zero modulus reports the value as gcd
                    r0_next   = a_in;
                    u0_next   = '0;
                    mod_next  = m_in;
                    odd_next  = 1'b0;
                    zmod_next = (m_in == '0);
                end
            end
            ST_REDUCE:
            begin
                if (div_status.done)
                begin
                    r0_next = mod_reg;
                    r1_next = div_rem;
                    u0_next = '0;
                    u1_next = WIDTH'(1);
                end
            end
            ST_DIVIDE:
            begin
                // one Euclid round: shift pairs, u2 = u0 + q * u1
                if (div_status.done)
                begin
                    r0_next  = r1_reg;
                    r1_next  = div_rem;
                    u0_next  = u1_reg;
                    u1_next  = u0_reg + div_prod;
                    odd_next = !odd_reg;
                end
            end
            default:
            begin
                r0_next = r0_reg;
            end
        endcase
    end

    // Normalize the coefficient into 0..modulus-1
    always_comb
    begin
        ok    = !zmod_reg && (r0_reg == WIDTH'(1));
        mag   = (u0_reg >= mod_reg) ? (u0_reg - mod_reg) : u0_reg;
        inv_w = '0;
        if (ok)
        begin
            if (odd_reg)
                inv_w = mag;
            else if (mag != '0)
                inv_w = mod_reg - mag;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        inverse_next   = inverse_reg;
        gcd_next       = gcd_reg;
        has_inv_next   = has_inv_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            inverse_next   = OUT_W'(inv_w);
            gcd_next       = OUT_W'(r0_reg);
            has_inv_next   = ok;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        u0_reg      <= u0_next;
        u1_reg      <= u1_next;
        mod_reg     <= mod_next;
        odd_reg     <= odd_next;
        zmod_reg    <= zmod_next;
        inverse_reg <= inverse_next;
        gcd_reg     <= gcd_next;
        has_inv_reg <= has_inv_next;
    end

    assign out_valid      = out_valid_reg;
    assign inverse        = inverse_reg;
    assign common_divisor = gcd_reg;
    assign has_inverse    = has_inv_reg;

    `MIE_ASSERT_IMP(a_idle_div_free, in_ready, !div_status.busy, "divider busy while idle")
    `MIE_ASSERT_IMP(a_inv_gcd_one, out_valid_reg && has_inv_reg,
                    gcd_reg == OUT_W'(1), "inverse flagged with gcd not one")
    `MIE_ASSERT_IMP(a_inv_zero_none, out_valid_reg && !has_inv_reg,
                    inverse_reg == '0, "nonzero inverse without flag")
    `MIE_ASSERT_NXT(a_done_in_wait, div_status.done,
                    state_reg == ST_CHECK, "divider result not consumed")

endmodule

`default_nettype wire
